// ===== hw/rtl/dcnr_pkg.sv =====
// Package for the depthwise convolution / norm / ReLU block.
// Holds sizes, action codes, state enum and the config struct; no dependencies.
`default_nettype none
package dcnr_pkg;
   localparam int MaxHeight   = 64;
   localparam int MaxWidth    = 64;
   localparam int MaxChannels = 32;
   localparam int MaxKernel   = 5;

   typedef enum logic [1:0] {
      ACT_WR_ACT   = 2'd0,
      ACT_WR_TAP   = 2'd1,
      ACT_WR_NORM  = 2'd2,
      ACT_COMPUTE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_WIN, ST_DRAIN, ST_MUL, ST_SUM, ST_OUT
   } state_type;

   // Config register indexes
   localparam logic [2:0] REG_KSIZE  = 3'd0;
   localparam logic [2:0] REG_STRIDE = 3'd1;
   localparam logic [2:0] REG_PAD    = 3'd2;
   localparam logic [2:0] REG_HEIGHT = 3'd3;
   localparam logic [2:0] REG_WIDTH  = 3'd4;
   localparam logic [2:0] REG_CHANS  = 3'd5;

   typedef struct packed {
      logic [2:0] ksize;
      logic [2:0] stride;
      logic [1:0] pad;
      logic [6:0] height;
      logic [6:0] width;
      logic [5:0] chans;
   } cfg_type;
endpackage
`default_nettype wire

// ===== hw/rtl/depthwise_conv_norm_relu.sv =====
// Depthwise conv + folded batch-norm + ReLU, top level with sequencer and datapath.
// Depends on dcnr_pkg, dcnr_csr, dcnr_mem.
//
// Usage: requests arrive on req_ (tvalid/tready/tdata). Actions 0..2 write
// the activation memory, a kernel tap, or a channel's scale/offset and give
// no response. Action 3 computes one output element and returns one
// response on rsp_ with result, running max and error. A compute walks the
// KxK window one tap per cycle through the activation and tap memories (one
// read port each, registered reads). Padded taps are still walked but add
// nothing. The sum is then multiplied by the scale in a registered step.
// A compute passes SETUP, the window walk, DRAIN, MUL, SUM and OUT before
// rsp_tvalid rises; an out-of-range compute goes straight to OUT. The next
// request is taken the cycle after the response handshake.
// One request is in flight at a time; req_tready is low while a compute runs.
// The response sits in an output register; if rsp_tready is low the block
// holds it and takes no new request until it is taken.
// Reset clears the sequencer, running max, response valid and configures
// kernel 3, stride 1, padding 1, 64x64 map, 32 channels. Memories are not
// cleared; reading unwritten entries gives undefined data.
// Configuration is to be written over csr_ only while the block is idle; the block itself does not enforce this.
`default_nettype none
module depthwise_conv_norm_relu #(
   parameter int MAX_HEIGHT   = dcnr_pkg::MaxHeight,
   parameter int MAX_WIDTH    = dcnr_pkg::MaxWidth,
   parameter int MAX_CHANNELS = dcnr_pkg::MaxChannels,
   parameter int MAX_KERNEL   = dcnr_pkg::MaxKernel
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // action[1:0] row[7:2] col[13:8] chan[18:14] tap[23:19] value[39:24]
   // shift_term[55:40] restart_max[56], zero fill to 64
   input  wire logic [63:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // result[14:0] running_max[29:15] error[30], zero fill [31]
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import dcnr_pkg::*;
   localparam int ActDepth = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
   localparam int TapDepth = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
   localparam int AAW = $clog2(ActDepth);
   localparam int TAW = $clog2(TapDepth);
   localparam int CW  = $clog2(MAX_CHANNELS);
   localparam int HW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH);
   // signed coordinate width: row*stride + k up to 63*7+5
   localparam int PW  = 11;

   cfg_type cfg;
   assign csr_pready = 1'b1;

   dcnr_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .cfg
   );

   // request fields
   action_type         f_action;
   logic [5:0]         f_row, f_col;
   logic [4:0]         f_chan, f_tap;
   logic signed [15:0] f_value, f_shift;
   logic               f_restart;
   assign f_action  = action_type'(req_tdata[1:0]);
   assign f_row     = req_tdata[7:2];
   assign f_col     = req_tdata[13:8];
   assign f_chan    = req_tdata[18:14];
   assign f_tap     = req_tdata[23:19];
   assign f_value   = req_tdata[39:24];
   assign f_shift   = req_tdata[55:40];
   assign f_restart = req_tdata[56];

   // effective config (out-of-range values clamped)
   logic [2:0] k_eff, s_eff;
   logic [6:0] h_eff, w_eff;
   logic [9:0] c_eff;
   always_comb begin
      k_eff = (cfg.ksize == 3'd0) ? 3'd1 :
              ({29'd0, cfg.ksize} > MAX_KERNEL) ? 3'(MAX_KERNEL) : cfg.ksize;
      s_eff = (cfg.stride == 3'd0) ? 3'd1 : cfg.stride;
      h_eff = (cfg.height == 7'd0) ? 7'd1 :
              ({25'd0, cfg.height} > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : cfg.height;
      w_eff = (cfg.width == 7'd0) ? 7'd1 :
              ({25'd0, cfg.width} > MAX_WIDTH) ? 7'(MAX_WIDTH) : cfg.width;
      c_eff = ({26'd0, cfg.chans} > MAX_CHANNELS) ? 10'(MAX_CHANNELS) : {4'd0, cfg.chans};
   end

   // Bound check without division: row valid iff row*s + k <= h + 2p.
   logic [PW-1:0] lim_h, lim_w, need_r, need_c;
   logic          coord_ok;
   always_comb begin
      lim_h  = PW'(h_eff) + PW'({cfg.pad, 1'b0});
      lim_w  = PW'(w_eff) + PW'({cfg.pad, 1'b0});
      need_r = PW'(f_row) * PW'(s_eff) + PW'(k_eff);
      need_c = PW'(f_col) * PW'(s_eff) + PW'(k_eff);
      coord_ok = (need_r <= lim_h) && (need_c <= lim_w) && ({5'd0, f_chan} < c_eff);
   end

   // sequencer state
   state_type st_ff, st_in;
   logic [2:0] kh_ff, kh_in, kw_ff, kw_in;
   logic [4:0] tap_ff, tap_in;
   logic signed [PW-1:0] base_r_ff, base_r_in, base_c_ff, base_c_in;
   logic [4:0] chan_ff, chan_in;
   logic       pv_ff, pv_in;        // read issued last cycle was in-map
   logic signed [36:0] acc_ff, acc_in;
   logic signed [53:0] prod_ff, prod_in;
   logic signed [55:0] tot_ff, tot_in;
   logic [14:0] max_ff, max_in, res_ff, res_in;
   logic        err_ff, err_in, rv_ff, rv_in;

   logic signed [PW-1:0] ih, iw;
   logic       in_map, last_tap;
   assign ih = base_r_ff + PW'(kh_ff);
   assign iw = base_c_ff + PW'(kw_ff);
   assign in_map = (ih >= 0) && (ih < PW'(h_eff)) && (iw >= 0) && (iw < PW'(w_eff));
   assign last_tap = (kh_ff == k_eff - 3'd1) && (kw_ff == k_eff - 3'd1);

   logic accept;
   assign req_tready = (st_ff == ST_IDLE) && !rv_ff;
   assign accept = req_tvalid && req_tready;

   // memory ports
   logic act_we, tap_we, norm_we;
   logic [AAW-1:0] act_addr;
   logic [TAW-1:0] tap_addr;
   logic [CW-1:0]  norm_addr;
   logic signed [15:0] act_rd, tap_rd;
   logic signed [31:0] norm_rd;

   always_comb begin
      act_we  = accept && f_action == ACT_WR_ACT &&
                {26'd0, f_row} < MAX_HEIGHT && {26'd0, f_col} < MAX_WIDTH &&
                {27'd0, f_chan} < MAX_CHANNELS;
      tap_we  = accept && f_action == ACT_WR_TAP &&
                {27'd0, f_tap} < MAX_KERNEL * MAX_KERNEL &&
                {27'd0, f_chan} < MAX_CHANNELS;
      norm_we = accept && f_action == ACT_WR_NORM && {27'd0, f_chan} < MAX_CHANNELS;
      if (st_ff == ST_WIN) begin
         act_addr  = AAW'((32'(ih[HW:0]) * MAX_WIDTH + 32'(iw[WW:0])) * MAX_CHANNELS
                     + 32'(chan_ff));
         tap_addr  = TAW'(32'(tap_ff) * MAX_CHANNELS + 32'(chan_ff));
         norm_addr = CW'(chan_ff);
      end else begin
         act_addr  = AAW'((32'(f_row) * MAX_WIDTH + 32'(f_col)) * MAX_CHANNELS
                     + 32'(f_chan));
         tap_addr  = TAW'(32'(f_tap) * MAX_CHANNELS + 32'(f_chan));
         norm_addr = CW'(st_ff == ST_IDLE ? f_chan : chan_ff);
      end
   end

   dcnr_mem #(
      .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH),
      .MAX_CHANNELS(MAX_CHANNELS), .MAX_KERNEL(MAX_KERNEL)
   ) u_mem (
      .clock,
      .act_we, .act_addr, .act_wdata(f_value), .act_rdata(act_rd),
      .tap_we, .tap_addr, .tap_wdata(f_value), .tap_rdata(tap_rd),
      .norm_we, .norm_addr, .norm_wdata({f_shift, f_value}), .norm_rdata(norm_rd)
   );

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (accept && f_action == ACT_COMPUTE)
                      st_in = coord_ok ? ST_SETUP : ST_OUT;
         ST_SETUP: st_in = ST_WIN;
         ST_WIN:   if (last_tap) st_in = ST_DRAIN;
         ST_DRAIN: st_in = ST_MUL;
         ST_MUL:   st_in = ST_SUM;
         ST_SUM:   st_in = ST_OUT;
         ST_OUT:   st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // datapath
   logic [55:0] q;
   always_comb begin
      kh_in = kh_ff; kw_in = kw_ff; tap_in = tap_ff;
      base_r_in = base_r_ff; base_c_in = base_c_ff; chan_in = chan_ff;
      pv_in = 1'b0; acc_in = acc_ff; prod_in = prod_ff; tot_in = tot_ff;
      max_in = max_ff; res_in = res_ff; err_in = err_ff; rv_in = rv_ff;
      q = 56'(tot_ff >>> 24);
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept && f_action == ACT_COMPUTE) begin
               if (f_restart) max_in = '0;
               err_in = !coord_ok;
               res_in = '0;
               chan_in = f_chan;
               base_r_in = PW'(f_row) * PW'(s_eff) - PW'(cfg.pad);
               base_c_in = PW'(f_col) * PW'(s_eff) - PW'(cfg.pad);
               kh_in = '0; kw_in = '0; tap_in = '0; acc_in = '0;
            end
         end
         ST_SETUP: ;
         ST_WIN: begin
            pv_in = in_map;
            tap_in = tap_ff + 5'd1;
            if (kw_ff == k_eff - 3'd1) begin
               kw_in = '0;
               kh_in = kh_ff + 3'd1;
            end else begin
               kw_in = kw_ff + 3'd1;
            end
         end
         ST_DRAIN: ;
         // scale and offset are signed halves of the norm word
         ST_MUL: prod_in = 54'(acc_ff) * 54'($signed(norm_rd[15:0]));
         ST_SUM: tot_in = 56'(prod_ff) + (56'($signed(norm_rd[31:16])) <<< 24)
                          + (56'sd1 <<< 23);
         ST_OUT: begin
            if (!err_ff) begin
               if (tot_ff < (56'sd1 <<< 24)) res_in = '0;
               else if (q > 56'd32767) res_in = 15'h7fff;
               else res_in = q[14:0];
               if (res_in > max_ff) max_in = res_in;
            end
            rv_in = 1'b1;
         end
         default: ;
      endcase
      // accumulate the product of the read issued last cycle
      if (pv_ff) acc_in = acc_ff + 37'(act_rd * tap_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         rv_ff  <= 1'b0;
         max_ff <= '0;
         pv_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         rv_ff  <= rv_in;
         max_ff <= max_in;
         pv_ff  <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      kh_ff <= kh_in; kw_ff <= kw_in; tap_ff <= tap_in;
      base_r_ff <= base_r_in; base_c_ff <= base_c_in; chan_ff <= chan_in;
      acc_ff <= acc_in; prod_ff <= prod_in; tot_ff <= tot_in;
      res_ff <= res_in; err_ff <= err_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {1'b0, err_ff, max_ff, res_ff};
endmodule
`default_nettype wire

// ===== hw/rtl/dcnr_csr.sv =====
// Configuration registers behind an APB-style port.
// Depends on dcnr_pkg.
`default_nettype none
module dcnr_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_psel,
   input  wire logic           csr_penable,
   input  wire logic           csr_pwrite,
   input  wire logic [4:0]     csr_paddr,
   input  wire logic [31:0]    csr_pwdata,
   output logic [31:0]         csr_prdata,
   output dcnr_pkg::cfg_type   cfg
);
   import dcnr_pkg::*;
   cfg_type cfg_ff, cfg_in;
   logic    wr;
   logic [2:0] idx;

   assign idx = csr_paddr[4:2];
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr && csr_paddr[1:0] == 2'd0) begin
         unique case (idx)
            REG_KSIZE:  cfg_in.ksize  = csr_pwdata[2:0];
            REG_STRIDE: cfg_in.stride = csr_pwdata[2:0];
            REG_PAD:    cfg_in.pad    = csr_pwdata[1:0];
            REG_HEIGHT: cfg_in.height = csr_pwdata[6:0];
            REG_WIDTH:  cfg_in.width  = csr_pwdata[6:0];
            REG_CHANS:  cfg_in.chans  = csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_KSIZE:  csr_prdata[2:0] = cfg_ff.ksize;
         REG_STRIDE: csr_prdata[2:0] = cfg_ff.stride;
         REG_PAD:    csr_prdata[1:0] = cfg_ff.pad;
         REG_HEIGHT: csr_prdata[6:0] = cfg_ff.height;
         REG_WIDTH:  csr_prdata[6:0] = cfg_ff.width;
         REG_CHANS:  csr_prdata[5:0] = cfg_ff.chans;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{ksize: 3'd3, stride: 3'd1, pad: 2'd1, height: 7'd64,
                     width: 7'd64, chans: 6'd32};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/dcnr_mem.sv =====
// Activation, tap and norm memories with registered reads.
// Depends on dcnr_pkg.
`default_nettype none
module dcnr_mem #(
   parameter int MAX_HEIGHT   = dcnr_pkg::MaxHeight,
   parameter int MAX_WIDTH    = dcnr_pkg::MaxWidth,
   parameter int MAX_CHANNELS = dcnr_pkg::MaxChannels,
   parameter int MAX_KERNEL   = dcnr_pkg::MaxKernel,
   localparam int ActDepth = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS,
   localparam int TapDepth = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS,
   localparam int AAW = $clog2(ActDepth),
   localparam int TAW = $clog2(TapDepth),
   localparam int CW  = $clog2(MAX_CHANNELS)
) (
   input  wire logic                clock,
   input  wire logic                act_we,
   input  wire logic [AAW-1:0]      act_addr,
   input  wire logic signed [15:0]  act_wdata,
   output logic signed [15:0]       act_rdata,
   input  wire logic                tap_we,
   input  wire logic [TAW-1:0]      tap_addr,
   input  wire logic signed [15:0]  tap_wdata,
   output logic signed [15:0]       tap_rdata,
   input  wire logic                norm_we,
   input  wire logic [CW-1:0]       norm_addr,
   input  wire logic signed [31:0]  norm_wdata,
   output logic signed [31:0]       norm_rdata
);
   logic signed [15:0] act_mem [ActDepth];
   logic signed [15:0] tap_mem [TapDepth];
   logic signed [31:0] norm_mem [MAX_CHANNELS];

   always_ff @(posedge clock) begin
      if (act_we) act_mem[act_addr] <= act_wdata;
      act_rdata <= act_mem[act_addr];
   end
   always_ff @(posedge clock) begin
      if (tap_we) tap_mem[tap_addr] <= tap_wdata;
      tap_rdata <= tap_mem[tap_addr];
   end
   always_ff @(posedge clock) begin
      if (norm_we) norm_mem[norm_addr] <= norm_wdata;
      norm_rdata <= norm_mem[norm_addr];
   end
endmodule
`default_nettype wire
